// ----- rtl/core/wvm_pkg.sv -----
package wvm_pkg;

	localparam int unsigned VOICES_DEF = 4;

	localparam int unsigned SETUP_W = 64;
	localparam int unsigned PHASE_W = 32;
	localparam int unsigned GAIN_W  = 16;
	localparam int unsigned PAN_W   = 12;
	localparam int unsigned SAMP_W  = 16;
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned OUT_W   = 24;
	localparam int unsigned MAG_W   = 15;

	localparam int unsigned INC_LSB    = 0;
	localparam int unsigned GAIN_LSB   = 32;
	localparam int unsigned PAN_LSB    = 48;
	localparam int unsigned SQUARE_BIT = 60;
	localparam int unsigned INTERP_BIT = 61;

	localparam int unsigned SINE_DEPTH = 1024;
	localparam int unsigned TBL_AW     = $clog2(SINE_DEPTH);
	localparam int unsigned QTR_SIZE   = SINE_DEPTH / 4;
	localparam int unsigned QTR_AW     = TBL_AW - 2;
	localparam int unsigned SQ_SIZE    = 256;
	localparam int unsigned SQ_AW      = $clog2(SQ_SIZE);

	localparam int unsigned MUL_A_W = 32;
	localparam int unsigned MUL_B_W = 17;
	localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
	localparam int unsigned WGT_W   = 13;
	localparam int unsigned TERM_W  = MUL_A_W + WGT_W;
	localparam int unsigned ROUND_SH = 23;

	localparam logic signed [SAMP_W-1:0] WAVE_POS = 16'sd32767;
	localparam logic signed [SAMP_W-1:0] WAVE_NEG = -16'sd32767;
	localparam logic signed [WGT_W-1:0]  WGT_UNITY = 13'sd1024;
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam logic [63:0] MAG_FULL    = 64'd32767;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ0,
		ST_READ1,
		ST_MULI,
		ST_ADDI,
		ST_GAIN,
		ST_LEFT,
		ST_RIGHT,
		ST_ACCR,
		ST_DONE
	} wvm_state_t;

	typedef enum logic [1:0] {
		MS_INTERP,
		MS_GAIN,
		MS_LEFT,
		MS_RIGHT
	} wvm_mul_sel_t;

	typedef struct packed {
		logic start;
		logic voice_on;
		logic interp;
		logic out_busy;
	} wvm_stat_t;

	typedef struct packed {
		logic         ready;
		logic         clear_acc;
		logic         load_samp;
		logic         idx_next;
		logic         load_diff;
		logic         mul_en;
		wvm_mul_sel_t mul_sel;
		logic         add_interp;
		logic         keep_g;
		logic         acc_l;
		logic         acc_r;
		logic         load_out;
	} wvm_ctrl_t;

	// Quarter-wave sine magnitude, Q30 Taylor series with nine terms
	function automatic logic [MAG_W-1:0] sine_mag(input int unsigned j);
		logic [63:0] f;
		logic [63:0] theta;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] mag;
		logic signed [63:0] sum;
		f = 64'(j) << (30 - QTR_AW);
		theta = (f * PI_HALF_Q30) >> 30;
		x2 = (theta * theta) >> 30;
		term = theta;
		sum = $signed(theta);
		term = ((term * x2) >> 30) / 64'd6;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd210;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd272;
		sum = sum + $signed(term);
		if (sum < 64'sd0) begin
			sum = 64'sd0;
		end
		if (sum > (64'sd1 <<< 30)) begin
			sum = 64'sd1 <<< 30;
		end
		mag = (64'(sum) * MAG_FULL + (64'd1 << 29)) >> 30;
		if (mag > MAG_FULL) begin
			mag = MAG_FULL;
		end
		return mag[MAG_W-1:0];
	endfunction

endpackage

// ----- rtl/core/wvm_wave.sv -----
module wvm_wave import wvm_pkg::*; (
	input  logic                     square,
	input  logic [TBL_AW-1:0]        idx,
	output logic signed [SAMP_W-1:0] entry
);

	localparam logic [MAG_W-1:0] QPeak = sine_mag(QTR_SIZE);

	logic [MAG_W-1:0]         qtab [QTR_SIZE];
	logic [1:0]               quad;
	logic [QTR_AW-1:0]        k;
	logic [QTR_AW-1:0]        kq;
	logic [MAG_W-1:0]         mag;
	logic signed [SAMP_W-1:0] smag;

	for (genvar j = 0; j < QTR_SIZE; j++) begin : g_tab
		assign qtab[j] = sine_mag(j);
	end

	assign quad = idx[TBL_AW-1 -: 2];
	assign k    = idx[QTR_AW-1:0];
	// mirror the odd quadrants
	assign kq   = quad[0] ? (~k + 1'b1) : k;

	always_comb begin
		if (quad[0] && (k == '0)) begin
			mag = QPeak;
		end else begin
			mag = qtab[kq];
		end
		smag = $signed({1'b0, mag});
		if (square) begin
			entry = idx[SQ_AW-1] ? WAVE_POS : WAVE_NEG;
		end else begin
			entry = quad[1] ? -smag : smag;
		end
	end

endmodule

// ----- rtl/core/wvm_seq.sv -----
module wvm_seq import wvm_pkg::*; #(
	parameter int unsigned VOICES = VOICES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  wvm_stat_t                  stat,
	output wvm_ctrl_t                  ctrl,
	output logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] voice
);

	localparam int unsigned VIdxW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam logic [VIdxW-1:0] LastVoice = VIdxW'(VOICES - 1);

	wvm_state_t       state_q;
	wvm_state_t       state_d;
	logic [VIdxW-1:0] voice_q;
	logic             last;
	logic             go;
	logic             step;

	assign last  = (voice_q == LastVoice);
	assign go    = (state_q == ST_IDLE) && in_valid && stat.start;
	assign step  = ((state_q == ST_READ0) && !stat.voice_on) || (state_q == ST_ACCR);
	assign voice = voice_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			voice_q <= '0;
		end else begin
			state_q <= state_d;
			if (go) begin
				voice_q <= '0;
			end else if (step && !last) begin
				voice_q <= voice_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (go) begin
					state_d = ST_READ0;
				end
			end
			ST_READ0: begin
				if (!stat.voice_on) begin
					state_d = last ? ST_DONE : ST_READ0;
				end else begin
					state_d = stat.interp ? ST_READ1 : ST_GAIN;
				end
			end
			ST_READ1: state_d = ST_MULI;
			ST_MULI:  state_d = ST_ADDI;
			ST_ADDI:  state_d = ST_GAIN;
			ST_GAIN:  state_d = ST_LEFT;
			ST_LEFT:  state_d = ST_RIGHT;
			ST_RIGHT: state_d = ST_ACCR;
			ST_ACCR:  state_d = last ? ST_DONE : ST_READ0;
			ST_DONE: begin
				if (!stat.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.mul_sel = MS_GAIN;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.ready     = 1'b1;
				ctrl.clear_acc = go;
			end
			ST_READ0: ctrl.load_samp = stat.voice_on;
			ST_READ1: begin
				ctrl.idx_next  = 1'b1;
				ctrl.load_diff = 1'b1;
			end
			ST_MULI: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MS_INTERP;
			end
			ST_ADDI:  ctrl.add_interp = 1'b1;
			ST_GAIN: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MS_GAIN;
			end
			ST_LEFT: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MS_LEFT;
				ctrl.keep_g  = 1'b1;
			end
			ST_RIGHT: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MS_RIGHT;
				ctrl.acc_l   = 1'b1;
			end
			ST_ACCR:  ctrl.acc_r = 1'b1;
			ST_DONE:  ctrl.load_out = !stat.out_busy;
			default:  ctrl = '0;
		endcase
	end

endmodule

// ----- rtl/core/wavetable_voice_mixer_core.sv -----
// Four-voice wavetable mixer, one stereo frame per tick beat.
// Input channel: in_valid/in_ready with tick. A beat with tick high starts a
// frame; a beat with tick low is taken and dropped, with no frame and no state
// change. in_ready is high only while no frame is being worked on.
// Output channel: out_valid/out_ready with left_sample, right_sample, clipped,
// held in an output register; a new tick is taken while it waits.
// Voice setup registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while idle, which the block does not enforce.
// An index at VOICES or above is ignored. All voices share one 32x17 signed
// multiplier; each voice runs a chain of sequencer states: a silent voice
// only reads (READ0), a plain voice runs READ0, GAIN, LEFT, RIGHT and ACCR,
// and an interpolated voice adds READ1, MULI and ADDI after READ0. If the
// previous result has not been taken when a frame finishes, the sequencer
// holds until out_ready.
// Reset clears phases, setup registers and out_valid; the sine table is
// constant logic and needs no fill.
module wavetable_voice_mixer_core import wvm_pkg::*; #(
	parameter int unsigned VOICES = VOICES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     tick,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [OUT_W-1:0]  left_sample,
	output logic signed [OUT_W-1:0]  right_sample,
	output logic                     clipped,
	input  logic                     cfg_we,
	input  logic [((VOICES > 1) ? $clog2(VOICES) : 1)-1:0] cfg_index,
	input  logic [SETUP_W-1:0]       cfg_data
);

	localparam int unsigned VIdxW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int unsigned AccW  = TERM_W + $clog2(VOICES) + 1;
	localparam logic signed [AccW-1:0] RoundBit = AccW'(1) <<< (ROUND_SH - 1);
	localparam logic signed [AccW-1:0] SatMax   = AccW'((2 ** (OUT_W - 1)) - 1);
	localparam logic signed [AccW-1:0] SatMin   = -SatMax - AccW'(1);

	function automatic logic [OUT_W:0] round_sat(input logic signed [AccW-1:0] acc);
		logic signed [AccW-1:0] r;
		logic [OUT_W:0]         res;
		r = (acc + RoundBit) >>> ROUND_SH;
		if (r > SatMax) begin
			res = {1'b1, SatMax[OUT_W-1:0]};
		end else if (r < SatMin) begin
			res = {1'b1, SatMin[OUT_W-1:0]};
		end else begin
			res = {1'b0, r[OUT_W-1:0]};
		end
		return res;
	endfunction

	logic [SETUP_W-1:0] setup_q [VOICES];
	logic [PHASE_W-1:0] phase_q [VOICES];

	wvm_ctrl_t        ctrl;
	wvm_stat_t        stat;
	logic [VIdxW-1:0] voice;

	logic [SETUP_W-1:0]       s;
	logic [PHASE_W-1:0]       ph;
	logic [PHASE_W-1:0]       inc;
	logic [GAIN_W-1:0]        gain;
	logic signed [PAN_W-1:0]  pan;
	logic                     square;
	logic                     interp;
	logic signed [WGT_W-1:0]  wl;
	logic signed [WGT_W-1:0]  wr;
	logic [TBL_AW-1:0]        i0;
	logic [TBL_AW-1:0]        i1;
	logic [SQ_AW-1:0]         sq0;
	logic [FRAC_W-1:0]        frac;
	logic [TBL_AW-1:0]        wave_idx;
	logic signed [SAMP_W-1:0] entry;

	logic signed [SAMP_W-1:0]  samp_q;
	logic signed [SAMP_W:0]    diff_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [MUL_A_W-1:0] g_q;
	logic signed [AccW-1:0]    accl_q;
	logic signed [AccW-1:0]    accr_q;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;

	logic                     out_valid_q;
	logic signed [OUT_W-1:0]  left_q;
	logic signed [OUT_W-1:0]  right_q;
	logic                     clip_q;
	logic [OUT_W:0]           sat_l;
	logic [OUT_W:0]           sat_r;

	assign s      = setup_q[voice];
	assign ph     = phase_q[voice];
	assign inc    = s[INC_LSB +: PHASE_W];
	assign gain   = s[GAIN_LSB +: GAIN_W];
	assign pan    = $signed(s[PAN_LSB +: PAN_W]);
	assign square = s[SQUARE_BIT];
	assign interp = s[INTERP_BIT];
	assign wl     = WGT_UNITY - WGT_W'(pan);
	assign wr     = WGT_UNITY + WGT_W'(pan);
	assign sq0    = ph[PHASE_W-1 -: SQ_AW];

	always_comb begin
		if (square) begin
			i0   = TBL_AW'(sq0);
			i1   = TBL_AW'(sq0 + 1'b1);
			frac = ph[PHASE_W-1-SQ_AW -: FRAC_W];
		end else begin
			i0   = ph[PHASE_W-1 -: TBL_AW];
			i1   = ph[PHASE_W-1 -: TBL_AW] + 1'b1;
			frac = ph[PHASE_W-1-TBL_AW -: FRAC_W];
		end
	end

	assign wave_idx = ctrl.idx_next ? i1 : i0;

	wvm_wave u_wave (
		.square (square),
		.idx    (wave_idx),
		.entry  (entry)
	);

	assign stat.start    = tick;
	assign stat.voice_on = (inc != '0) && (gain != '0);
	assign stat.interp   = interp;
	assign stat.out_busy = out_valid_q && !out_ready;

	wvm_seq #(
		.VOICES (VOICES)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.ctrl     (ctrl),
		.voice    (voice)
	);

	always_comb begin
		case (ctrl.mul_sel)
			MS_INTERP: begin
				mul_a = MUL_A_W'(diff_q);
				mul_b = $signed({1'b0, frac});
			end
			MS_GAIN: begin
				mul_a = MUL_A_W'(samp_q);
				mul_b = $signed({1'b0, gain});
			end
			MS_LEFT: begin
				mul_a = $signed(prod_q[MUL_A_W-1:0]);
				mul_b = MUL_B_W'(wl);
			end
			MS_RIGHT: begin
				mul_a = g_q;
				mul_b = MUL_B_W'(wr);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_samp) begin
			samp_q <= entry;
		end else if (ctrl.add_interp) begin
			samp_q <= samp_q + $signed(prod_q[FRAC_W +: SAMP_W]);
		end
		if (ctrl.load_diff) begin
			diff_q <= $signed({entry[SAMP_W-1], entry}) - $signed({samp_q[SAMP_W-1], samp_q});
		end
		if (ctrl.mul_en) begin
			prod_q <= PROD_W'(mul_a * mul_b);
		end
		if (ctrl.keep_g) begin
			g_q <= $signed(prod_q[MUL_A_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accl_q <= '0;
			accr_q <= '0;
			for (int i = 0; i < VOICES; i++) begin
				setup_q[i] <= '0;
				phase_q[i] <= '0;
			end
		end else begin
			if (ctrl.clear_acc) begin
				accl_q <= '0;
				accr_q <= '0;
			end else begin
				if (ctrl.acc_l) begin
					accl_q <= accl_q + AccW'(prod_q);
				end
				if (ctrl.acc_r) begin
					accr_q <= accr_q + AccW'(prod_q);
				end
			end
			if (ctrl.acc_r) begin
				phase_q[voice] <= ph + inc;
			end
			if (cfg_we && (int'(cfg_index) < VOICES)) begin
				setup_q[cfg_index] <= cfg_data;
			end
		end
	end

	assign sat_l = round_sat(accl_q);
	assign sat_r = round_sat(accr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			left_q  <= $signed(sat_l[OUT_W-1:0]);
			right_q <= $signed(sat_r[OUT_W-1:0]);
			clip_q  <= sat_l[OUT_W] || sat_r[OUT_W];
		end
	end

	assign in_ready     = ctrl.ready;
	assign out_valid    = out_valid_q;
	assign left_sample  = left_q;
	assign right_sample = right_q;
	assign clipped      = clip_q;

endmodule

// ----- rtl/core/wvm_chk.sv -----
module wvm_chk import wvm_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    tick,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [OUT_W-1:0] left_sample,
	input logic signed [OUT_W-1:0] right_sample,
	input logic                    clipped
);

	localparam logic signed [OUT_W-1:0] RailHi = {1'b0, {(OUT_W - 1){1'b1}}};
	localparam logic signed [OUT_W-1:0] RailLo = {1'b1, {(OUT_W - 1){1'b0}}};

	a_busy_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && tick |=> !in_ready)
		else $error("frame start did not drop in_ready");

	a_idle_after_drop: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !tick |=> in_ready)
		else $error("empty beat started a frame");

	a_clip_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> (left_sample == RailHi) || (left_sample == RailLo) ||
			(right_sample == RailHi) || (right_sample == RailLo))
		else $error("clipped set with neither channel at a rail");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_sample) &&
			$stable(right_sample) && $stable(clipped))
		else $error("stalled result beat changed");

endmodule

bind wavetable_voice_mixer_core wvm_chk u_wvm_chk (.*);

// ----- dv/wavetable_voice_mixer_core_tb.sv -----
module wavetable_voice_mixer_core_tb;
	import wvm_pkg::*;

	localparam int NV = VOICES_DEF;
	localparam int IDX_W = (NV > 1) ? $clog2(NV) : 1;
	localparam int SETTLE = 40;
	localparam int LIMIT = 400000;
	localparam int RANDOM_BEATS = 700;

	typedef struct packed {
		logic signed [OUT_W-1:0] left;
		logic signed [OUT_W-1:0] right;
		logic                    clip;
	} frame_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      tick = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [OUT_W-1:0]   left_sample;
	logic signed [OUT_W-1:0]   right_sample;
	logic                      clipped;
	logic                      cfg_we = 1'b0;
	logic [IDX_W-1:0]          cfg_index = '0;
	logic [SETUP_W-1:0]        cfg_data = '0;

	logic signed [SAMP_W-1:0]  sine_rom [SINE_DEPTH];
	logic [PHASE_W-1:0]        voice_phase [NV];
	logic [SETUP_W-1:0]        voice_cfg [NV];
	frame_t                    frames_due [$];

	int fails = 0;
	int cycles = 0;
	bit pace_gaps = 1'b1;
	bit valid_held = 1'b0;
	int burst_left = 1;
	int stall_pct = 0;
	int stall_span = 0;
	int hold_req = 0;
	int hold_left = 0;

	wavetable_voice_mixer_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.tick         (tick),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.clipped      (clipped),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic logic signed [SAMP_W-1:0] sine_point(input logic [31:0] ph);
		logic [63:0] f;
		logic [63:0] theta;
		logic [63:0] x2;
		logic [63:0] term;
		longint acc;
		longint mag;
		int k;
		f = {34'd0, ph[29:0]};
		if (ph[30]) begin
			f = (64'd1 << 30) - f;
		end
		theta = (f * 64'd1686629713) >> 30;
		x2 = (theta * theta) >> 30;
		term = theta;
		acc = longint'(theta);
		for (k = 1; k <= 8; k++) begin
			term = ((term * x2) >> 30) / 64'(2 * k * (2 * k + 1));
			if (k % 2 == 1) begin
				acc -= longint'(term);
			end else begin
				acc += longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > (longint'(1) <<< 30)) begin
			acc = longint'(1) <<< 30;
		end
		mag = (acc * 32767 + (longint'(1) <<< 29)) >>> 30;
		if (mag > 32767) begin
			mag = 32767;
		end
		return ph[31] ? SAMP_W'(-mag) : SAMP_W'(mag);
	endfunction

	function automatic longint wave_at(input logic sq, input int unsigned idx);
		if (sq) begin
			return (idx < SQ_SIZE / 2) ? longint'(WAVE_NEG) : longint'(WAVE_POS);
		end
		return longint'(sine_rom[idx]);
	endfunction

	function automatic longint round_sat(input longint acc, inout logic clip);
		longint v;
		v = (acc + (longint'(1) <<< 22)) >>> ROUND_SH;
		if (v > 8388607) begin
			clip = 1'b1;
			v = 8388607;
		end else if (v < -8388608) begin
			clip = 1'b1;
			v = -8388608;
		end
		return v;
	endfunction

	function automatic frame_t mix_frame();
		frame_t fr;
		logic [SETUP_W-1:0] s;
		logic [63:0] prod;
		logic sq;
		int unsigned size;
		int unsigned i0;
		int unsigned i1;
		longint frac;
		longint gain;
		longint pan;
		longint t0;
		longint samp;
		longint g;
		longint acc_l;
		longint acc_r;
		logic clip;
		acc_l = 0;
		acc_r = 0;
		clip = 1'b0;
		for (int v = 0; v < NV; v++) begin
			s = voice_cfg[v];
			gain = longint'(s[GAIN_LSB +: GAIN_W]);
			if (s[INC_LSB +: PHASE_W] == '0 || gain == 0) begin
				continue;
			end
			pan = longint'($signed(s[PAN_LSB +: PAN_W]));
			sq = s[SQUARE_BIT];
			size = sq ? SQ_SIZE : SINE_DEPTH;
			prod = {32'd0, voice_phase[v]} * 64'(size);
			i0 = prod[63:32];
			frac = longint'(prod[31:16]);
			t0 = wave_at(sq, i0);
			samp = t0;
			if (s[INTERP_BIT]) begin
				i1 = (i0 + 1 >= size) ? 0 : i0 + 1;
				samp = t0 + (((wave_at(sq, i1) - t0) * frac) >>> 16);
			end
			voice_phase[v] = voice_phase[v] + s[INC_LSB +: PHASE_W];
			g = samp * gain;
			acc_l += g * (1024 - pan);
			acc_r += g * (1024 + pan);
		end
		fr.left = OUT_W'(round_sat(acc_l, clip));
		fr.right = OUT_W'(round_sat(acc_r, clip));
		fr.clip = clip;
		return fr;
	endfunction

	function automatic logic [SETUP_W-1:0] rand_setup();
		logic [SETUP_W-1:0] s;
		s = {$urandom, $urandom};
		case ($urandom_range(7))
			0: s[INC_LSB +: PHASE_W] = '0;
			1: s[INC_LSB +: PHASE_W] = '1;
			2: s[INC_LSB +: PHASE_W] = $urandom_range(4095);
			default: ;
		endcase
		case ($urandom_range(7))
			0: s[GAIN_LSB +: GAIN_W] = '0;
			1: s[GAIN_LSB +: GAIN_W] = '1;
			2: s[GAIN_LSB +: GAIN_W] = 16'h1000;
			3: s[GAIN_LSB +: GAIN_W] = GAIN_W'($urandom_range(4096));
			default: ;
		endcase
		case ($urandom_range(5))
			0: s[PAN_LSB +: PAN_W] = '0;
			1: s[PAN_LSB +: PAN_W] = 12'h7FF;
			2: s[PAN_LSB +: PAN_W] = 12'h800;
			3: s[PAN_LSB +: PAN_W] = PAN_W'($urandom_range(2048)) - 12'd1024;
			default: ;
		endcase
		return s;
	endfunction

	task automatic send_beat(input logic t);
		in_valid <= 1'b1;
		tick <= t;
		valid_held = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (t) begin
			frames_due.push_back(mix_frame());
		end
		if (pace_gaps) begin
			burst_left--;
			if (burst_left <= 0) begin
				in_valid <= 1'b0;
				valid_held = 1'b0;
				repeat ($urandom_range(6, 1)) @(posedge clk);
				burst_left = $urandom_range(12, 1);
			end
		end
	endtask

	task automatic settle();
		if (valid_held) begin
			in_valid <= 1'b0;
			valid_held = 1'b0;
		end
		while (frames_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic load_voices(input logic [SETUP_W-1:0] setups [NV]);
		for (int i = 0; i < NV; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= IDX_W'(i);
			cfg_data <= setups[i];
			@(posedge clk);
			voice_cfg[i] = setups[i];
		end
		cfg_we <= 1'b0;
	endtask

	task automatic test_reset_silence();
		send_beat(1'b1);
		send_beat(1'b0);
		send_beat(1'b1);
	endtask

	task automatic test_single_sine();
		logic [SETUP_W-1:0] setups [NV];
		setups[0] = {2'b00, 1'b0, 1'b0, 12'h000, 16'h1000, 32'h0040_0000};
		setups[1] = {2'b00, 1'b0, 1'b0, 12'h000, 16'hFFFF, 32'h0000_0000};
		setups[2] = {2'b00, 1'b0, 1'b0, 12'h000, 16'h0000, 32'h0000_0005};
		setups[3] = '0;
		settle();
		load_voices(setups);
		repeat (3) send_beat(1'b1);
	endtask

	task automatic test_waveforms_interp();
		logic [SETUP_W-1:0] setups [NV];
		setups[0] = {2'b00, 1'b1, 1'b1, 12'h3FF, 16'h1000, 32'h0123_4567};
		setups[1] = {2'b00, 1'b1, 1'b0, 12'h800, 16'h8000, 32'hFFFF_FFFF};
		setups[2] = {2'b11, 1'b1, 1'b0, 12'hC00, 16'h0800, 32'h8000_0000};
		setups[3] = {2'b00, 1'b0, 1'b1, 12'h401, 16'h2000, 32'h4000_0000};
		settle();
		load_voices(setups);
		repeat (4) send_beat(1'b1);
	endtask

	task automatic test_saturation();
		logic [SETUP_W-1:0] setups [NV];
		for (int i = 0; i < NV; i++) begin
			setups[i] = {2'b00, 1'b0, 1'b1, 12'h7FF, 16'hFFFF, 32'h8000_0000};
		end
		settle();
		load_voices(setups);
		repeat (3) send_beat(1'b1);
		for (int i = 0; i < NV; i++) begin
			setups[i] = '1;
		end
		settle();
		load_voices(setups);
		repeat (3) send_beat(1'b1);
	endtask

	task automatic test_random_mixes();
		logic [SETUP_W-1:0] setups [NV];
		int sent;
		sent = 0;
		while (sent < RANDOM_BEATS) begin
			settle();
			for (int i = 0; i < NV; i++) begin
				setups[i] = rand_setup();
			end
			load_voices(setups);
			pace_gaps = ($urandom_range(3) != 0);
			for (int n = 0; n < 35; n++) begin
				if ($urandom_range(9) == 0) begin
					send_beat(1'b0);
				end else begin
					send_beat(1'b1);
				end
				sent++;
			end
		end
	endtask

	task automatic test_output_stall();
		logic [SETUP_W-1:0] setups [NV];
		for (int i = 0; i < NV; i++) begin
			setups[i] = rand_setup();
			setups[i][INTERP_BIT] = 1'b1;
		end
		settle();
		load_voices(setups);
		pace_gaps = 1'b0;
		hold_req = 400;
		repeat (25) send_beat(1'b1);
		pace_gaps = 1'b1;
	endtask

	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (stall_span == 0) begin
			stall_span = $urandom_range(200, 20);
			case ($urandom_range(2))
				0: stall_pct = 0;
				1: stall_pct = 30;
				default: stall_pct = 70;
			endcase
		end else begin
			stall_span--;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		frame_t want;
		if (arst_n && out_valid && out_ready) begin
			if (frames_due.size() == 0) begin
				$error("unexpected frame: left %0d right %0d clipped %0b",
					left_sample, right_sample, clipped);
				fails++;
			end else begin
				want = frames_due.pop_front();
				if (left_sample !== want.left) begin
					$error("left_sample: expected %0d, actual %0d", want.left, left_sample);
					fails++;
				end
				if (right_sample !== want.right) begin
					$error("right_sample: expected %0d, actual %0d", want.right, right_sample);
					fails++;
				end
				if (clipped !== want.clip) begin
					$error("clipped: expected %0b, actual %0b", want.clip, clipped);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("wavetable_voice_mixer_core_tb failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < SINE_DEPTH; i++) begin
			sine_rom[i] = sine_point(32'(i) << 22);
		end
		for (int i = 0; i < NV; i++) begin
			voice_phase[i] = '0;
			voice_cfg[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_silence();
		test_single_sine();
		test_waveforms_interp();
		test_saturation();
		test_random_mixes();
		test_output_stall();
		settle();
		if (fails == 0) begin
			$display("wavetable_voice_mixer_core_tb passed");
		end else begin
			$display("wavetable_voice_mixer_core_tb failed");
		end
		$finish;
	end

endmodule
